>>> rtl/obab_pkg.sv
`timescale 1ns / 1ps
package obab_pkg;

    localparam int unsigned CFG_W      = 17;
    localparam logic [16:0] MIN_ABS_RST = 17'd655;
    localparam logic [7:0]  KIND_BOX    = 8'd0;
    localparam logic [34:0] Q28_ONE     = 35'd268435456;
    localparam logic [33:0] EXT_CAP     = 34'h200000000;
    localparam logic [66:0] RND_HALF    = 67'd268435456;

    typedef struct packed {
        logic [7:0]         shape_kind;
        logic signed [15:0] rot_w;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } t_out;

endpackage

>>> rtl/oriented_box_to_aabb.sv
`timescale 1ns / 1ps
// Oriented box to axis-aligned bounding box.
// Input channel: i_valid / o_stall with one t_in beat per box primitive.
// A beat is taken at a rising edge with i_valid high and o_stall low.
// Only the box kind yields a result beat; other kinds are taken and dropped.
// Output channel: o_valid / i_stall with one t_out beat (min and max corner).
// Five register stages lie between input beat and output beat; throughput is
// one beat per cycle while the receiver does not stall, through these stages:
//   1 quaternion products and clamped absolute scales
//   2 rotation matrix entries, absolute values
//   3 nine |m| * scale products (33 x 32 bits)
//   4 row sums, round to Q16.16, cap the extent
//   5 position plus and minus extent, saturate to 32 bits
// Each stage advances when it is empty or the next one advances, so
// bubbles are squeezed out while the receiver stalls and o_stall rises only
// once every stage holds a beat. A stalled output beat holds steady.
// Reset (synchronous, active low) empties the pipeline and loads the
// minimum-scale register with about 0.01. Write it via i_cfg_we while idle.
module oriented_box_to_aabb
    import obab_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in              i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out             o_data,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_min_abs;

    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: xx,yy,zz,xy,xz,yz,wx,wy,wz
    logic signed [31:0] r1_p   [9];
    logic signed [31:0] n_p    [9];
    logic        [31:0] r1_a   [3];
    logic        [31:0] n_a    [3];
    logic signed [31:0] r1_pos [3];
    // stage 2
    logic        [32:0] r2_m   [9];
    logic        [32:0] n_m    [9];
    logic signed [34:0] m_s    [9];
    logic        [31:0] r2_a   [3];
    logic signed [31:0] r2_pos [3];
    // stage 3
    logic        [64:0] r3_pr  [9];
    logic signed [31:0] r3_pos [3];
    // stage 4
    logic        [33:0] r4_e   [3];
    logic        [33:0] n_e    [3];
    logic        [66:0] sum    [3];
    logic signed [31:0] r4_pos [3];
    // stage 5
    t_out               r_out;
    logic signed [31:0] n_lo   [3];
    logic signed [31:0] n_hi   [3];

    logic signed [31:0] scl [3];
    logic signed [31:0] pin [3];

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < -36'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // advance chain from the output back
    assign rdy5    = !r5_v || !i_stall;
    assign rdy4    = !r4_v || rdy5;
    assign rdy3    = !r3_v || rdy4;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_stall = !rdy1;
    assign o_valid = r5_v;
    assign o_data  = r_out;

    assign scl = '{i_data.scale_x, i_data.scale_y, i_data.scale_z};
    assign pin = '{i_data.pos_x, i_data.pos_y, i_data.pos_z};

    always_comb begin
        n_p[0] = i_data.rot_x * i_data.rot_x;
        n_p[1] = i_data.rot_y * i_data.rot_y;
        n_p[2] = i_data.rot_z * i_data.rot_z;
        n_p[3] = i_data.rot_x * i_data.rot_y;
        n_p[4] = i_data.rot_x * i_data.rot_z;
        n_p[5] = i_data.rot_y * i_data.rot_z;
        n_p[6] = i_data.rot_w * i_data.rot_x;
        n_p[7] = i_data.rot_w * i_data.rot_y;
        n_p[8] = i_data.rot_w * i_data.rot_z;
        for (int i = 0; i < 3; i++) begin
            // two's complement negate of the minimum gives 2^31 as unsigned
            n_a[i] = scl[i][31] ? (32'd0 - scl[i]) : scl[i];
            if (n_a[i] < 32'(r_min_abs)) begin
                n_a[i] = 32'(r_min_abs);
            end
        end
    end

    always_comb begin
        m_s[0] = Q28_ONE - ((35'(r1_p[1]) + 35'(r1_p[2])) <<< 1);
        m_s[1] = (35'(r1_p[3]) - 35'(r1_p[8])) <<< 1;
        m_s[2] = (35'(r1_p[4]) + 35'(r1_p[7])) <<< 1;
        m_s[3] = (35'(r1_p[3]) + 35'(r1_p[8])) <<< 1;
        m_s[4] = Q28_ONE - ((35'(r1_p[0]) + 35'(r1_p[2])) <<< 1);
        m_s[5] = (35'(r1_p[5]) - 35'(r1_p[6])) <<< 1;
        m_s[6] = (35'(r1_p[4]) - 35'(r1_p[7])) <<< 1;
        m_s[7] = (35'(r1_p[5]) + 35'(r1_p[6])) <<< 1;
        m_s[8] = Q28_ONE - ((35'(r1_p[0]) + 35'(r1_p[1])) <<< 1);
        for (int i = 0; i < 9; i++) begin
            n_m[i] = m_s[i][34] ? 33'(-m_s[i]) : m_s[i][32:0];
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            // units 2^-45; add half an LSB of Q16.16, then drop 29 bits
            sum[r] = 67'(r3_pr[3*r]) + 67'(r3_pr[3*r+1]) + 67'(r3_pr[3*r+2]) + RND_HALF;
            n_e[r] = (sum[r][66:29] > 38'(EXT_CAP)) ? EXT_CAP : sum[r][62:29];
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_lo[r] = sat32(36'(r4_pos[r]) - $signed({2'b00, r4_e[r]}));
            n_hi[r] = sat32(36'(r4_pos[r]) + $signed({2'b00, r4_e[r]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_abs <= MIN_ABS_RST;
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r5_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_abs <= i_cfg_data;
            end
            // drop non-box kinds at entry
            if (rdy1) r1_v <= i_valid && (i_data.shape_kind == KIND_BOX);
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
            if (rdy5) r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_p   <= n_p;
            r1_a   <= n_a;
            r1_pos <= pin;
        end
        if (rdy2) begin
            r2_m   <= n_m;
            r2_a   <= r1_a;
            r2_pos <= r1_pos;
        end
        if (rdy3) begin
            for (int i = 0; i < 9; i++) begin
                r3_pr[i] <= 65'(r2_m[i]) * 65'(r2_a[i%3]);
            end
            r3_pos <= r2_pos;
        end
        if (rdy4) begin
            r4_e   <= n_e;
            r4_pos <= r3_pos;
        end
        if (rdy5) begin
            r_out.min_x <= n_lo[0];
            r_out.min_y <= n_lo[1];
            r_out.min_z <= n_lo[2];
            r_out.max_x <= n_hi[0];
            r_out.max_y <= n_hi[1];
            r_out.max_z <= n_hi[2];
        end
    end

endmodule
